// ===== rtl/asu_pkg.sv =====
package asu_pkg;

  // longest name in the escape table, in bytes
  localparam int NAME_MAX = 10;
  // longest numeric escape body, in bytes
  localparam int HEX_MAX = 6;
  localparam int NAME_COUNT = 67;

  // largest character code an escape may produce
  localparam logic [6:0] CODE_MAX = 7'd127;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOW_X   = 8'h78;
  localparam logic [7:0] CH_UP_X    = 8'h58;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [6:0] out_byte;
    logic       is_end;
    logic       failed;
  } out_item_t;

  // outcome of decoding one escape body
  typedef struct packed {
    logic       ok;
    logic [6:0] code;
  } resolve_t;

  // text is right aligned: the last character sits in the low byte
  typedef struct packed {
    logic [6:0]            code;
    logic [3:0]            len;
    logic [NAME_MAX*8-1:0] text;
  } name_entry_t;

  localparam name_entry_t NAME_ROM [NAME_COUNT] = '{
    '{7'd1, 4'd3, "SOH"}, '{7'd2, 4'd3, "STX"}, '{7'd3, 4'd3, "ETX"},
    '{7'd4, 4'd3, "EOT"}, '{7'd5, 4'd3, "ENQ"}, '{7'd6, 4'd3, "ACK"},
    '{7'd7, 4'd1, "a"}, '{7'd8, 4'd1, "b"}, '{7'd9, 4'd1, "t"},
    '{7'd10, 4'd1, "n"}, '{7'd11, 4'd1, "v"}, '{7'd12, 4'd1, "f"},
    '{7'd13, 4'd1, "r"}, '{7'd14, 4'd2, "SO"}, '{7'd15, 4'd2, "SI"},
    '{7'd16, 4'd3, "DLE"}, '{7'd17, 4'd3, "DC1"}, '{7'd18, 4'd3, "DC2"},
    '{7'd19, 4'd3, "DC3"}, '{7'd20, 4'd3, "DC4"}, '{7'd21, 4'd3, "NAK"},
    '{7'd22, 4'd3, "SYN"}, '{7'd23, 4'd3, "ETB"}, '{7'd24, 4'd3, "CAN"},
    '{7'd25, 4'd2, "EM"}, '{7'd26, 4'd3, "SUB"}, '{7'd27, 4'd1, "e"},
    '{7'd28, 4'd2, "FS"}, '{7'd29, 4'd2, "GS"}, '{7'd30, 4'd2, "RS"},
    '{7'd31, 4'd2, "US"}, '{7'd127, 4'd3, "DEL"},
    '{7'd32, 4'd5, "space"}, '{7'd33, 4'd4, "bang"}, '{7'd34, 4'd5, "quote"},
    '{7'd35, 4'd4, "hash"}, '{7'd36, 4'd6, "dollar"}, '{7'd37, 4'd1, "%"},
    '{7'd37, 4'd7, "percent"}, '{7'd38, 4'd3, "amp"}, '{7'd39, 4'd0, ""},
    '{7'd39, 4'd4, "tick"}, '{7'd40, 4'd6, "lparen"}, '{7'd41, 4'd6, "rparen"},
    '{7'd42, 4'd4, "star"}, '{7'd43, 4'd4, "plus"}, '{7'd44, 4'd5, "comma"},
    '{7'd45, 4'd4, "dash"}, '{7'd46, 4'd3, "dot"}, '{7'd47, 4'd5, "slash"},
    '{7'd58, 4'd5, "colon"}, '{7'd59, 4'd4, "semi"}, '{7'd60, 4'd6, "langle"},
    '{7'd61, 4'd5, "equal"}, '{7'd62, 4'd6, "rangle"},
    '{7'd63, 4'd8, "question"}, '{7'd64, 4'd2, "at"},
    '{7'd91, 4'd8, "lbracket"}, '{7'd92, 4'd9, "backslash"},
    '{7'd93, 4'd8, "rbracket"}, '{7'd94, 4'd5, "caret"},
    '{7'd95, 4'd10, "underscore"}, '{7'd96, 4'd8, "backtick"},
    '{7'd123, 4'd6, "lbrace"}, '{7'd124, 4'd4, "pipe"},
    '{7'd125, 4'd6, "rbrace"}, '{7'd126, 4'd5, "tilde"}
  };

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
    end else begin
      d = c - 8'h37;
    end
    hex_digit = d[3:0];
  endfunction

  function automatic logic is_text(input logic [7:0] c);
    is_text = (c >= 8'h09 && c <= 8'h0D) || (c >= 8'h20 && c <= 8'h7E);
  endfunction

endpackage

// ===== rtl/asu_resolve.sv =====
module asu_resolve #(
  parameter int CNT_W = 4
) (
  input  logic [asu_pkg::NAME_MAX-1:0][7:0] body,
  input  logic [CNT_W-1:0]                  count,
  output asu_pkg::resolve_t                 res
);
  import asu_pkg::*;

  logic            numeric;
  logic            pfx;
  logic            running;
  logic [4*HEX_MAX-1:0] hex_v;
  logic            name_hit;
  logic [6:0]      name_code;
  logic            match;
  int              pos;

  assign numeric = (count != '0) && (body[0] >= CH_ZERO) && (body[0] <= CH_NINE);

  // numeric body: optional 0x prefix, then hex digits up to the first other byte
  always_comb begin
    pfx = (count >= CNT_W'(3)) && (body[0] == CH_ZERO) &&
          ((body[1] == CH_LOW_X) || (body[1] == CH_UP_X)) && is_hex(body[2]);
    running = 1'b1;
    hex_v   = '0;
    for (int i = 0; i < HEX_MAX; i++) begin
      if (i >= 2 || !pfx) begin
        if (running && (CNT_W'(i) < count) && is_hex(body[i])) begin
          hex_v = {hex_v[4*HEX_MAX-5:0], hex_digit(body[i])};
        end else begin
          running = 1'b0;
        end
      end
    end
  end

  // name body: parallel compare against the table, first entry wins
  always_comb begin
    name_hit  = 1'b0;
    name_code = '0;
    match     = 1'b0;
    pos       = 0;
    for (int k = 0; k < NAME_COUNT; k++) begin
      match = (count == CNT_W'(NAME_ROM[k].len));
      for (int j = 0; j < NAME_MAX; j++) begin
        if (j < int'(NAME_ROM[k].len)) begin
          pos = int'(NAME_ROM[k].len) - 1 - j;
          if (body[j] != NAME_ROM[k].text[pos*8 +: 8]) begin
            match = 1'b0;
          end
        end
      end
      if (match && !name_hit) begin
        name_hit  = 1'b1;
        name_code = NAME_ROM[k].code;
      end
    end
  end

  always_comb begin
    if (numeric) begin
      res.ok   = (count <= CNT_W'(HEX_MAX)) &&
                 (hex_v <= {{(4*HEX_MAX-7){1'b0}}, CODE_MAX});
      res.code = hex_v[6:0];
    end else begin
      res.ok   = name_hit;
      res.code = name_code;
    end
  end

endmodule

// ===== rtl/ascii_string_unescape_unit.sv =====
// channel | ports                         | payload
// input   | in_valid, in_stall, in_data   | in_byte, is_last
// result  | out_valid, out_stall, out_data| out_byte, is_end, failed
//
// one byte per cycle sustained while out_stall stays low; a byte's result passes
// through the input register, then decode into the result register
// the escape name compare runs in parallel on the terminating ';'
// synchronous active-low reset clears the decode state and both valid flags
// out_stall holds the result register; in_stall rises only once the input
// register is also occupied
module ascii_string_unescape_unit #(
  parameter int BODY_BYTES = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  asu_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output asu_pkg::out_item_t out_data
);
  import asu_pkg::*;

  localparam int CNT_W = $clog2(BODY_BYTES + 1);
  localparam int IDX_W = $clog2(BODY_BYTES);

  in_item_t   s1_r;
  logic       s1_valid_r;
  out_item_t  out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       expect_open_r, expect_open_nxt;
  logic       in_escape_r, in_escape_nxt;
  logic       error_seen_r, error_seen_nxt;
  logic [CNT_W-1:0] body_count_r, body_count_nxt;
  logic [7:0] body_r [BODY_BYTES];
  logic       body_we;

  logic       out_free;
  logic       fire;
  logic [NAME_MAX-1:0][7:0] body_view;
  resolve_t   res;

  assign out_free  = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_r <= in_data;
    end
  end

  // escape body seen by the decoder
  always_comb begin
    for (int i = 0; i < NAME_MAX; i++) begin
      body_view[i] = body_r[i];
    end
  end

  asu_resolve #(
    .CNT_W(CNT_W)
  ) u_resolve (
    .body  (body_view),
    .count (body_count_r),
    .res   (res)
  );

  // per-byte decode
  always_comb begin
    expect_open_nxt = expect_open_r;
    in_escape_nxt   = in_escape_r;
    error_seen_nxt  = error_seen_r;
    body_count_nxt  = body_count_r;
    body_we         = 1'b0;
    out_nxt         = '0;
    out_valid_nxt   = out_valid_r && out_stall;
    if (fire) begin
      priority if (expect_open_r) begin
        expect_open_nxt = 1'b0;
        if (s1_r.is_last) begin
          expect_open_nxt = 1'b1;
          in_escape_nxt   = 1'b0;
          error_seen_nxt  = 1'b0;
          body_count_nxt  = '0;
          out_valid_nxt   = 1'b1;
          out_nxt.is_end  = 1'b1;
        end
      end else if (s1_r.is_last) begin
        expect_open_nxt = 1'b1;
        in_escape_nxt   = 1'b0;
        error_seen_nxt  = 1'b0;
        body_count_nxt  = '0;
        out_valid_nxt   = 1'b1;
        out_nxt.is_end  = 1'b1;
        out_nxt.failed  = error_seen_r || in_escape_r;
      end else if (error_seen_r) begin
        // drop everything up to the closing delimiter
      end else if (in_escape_r) begin
        if (s1_r.in_byte == CH_SEMI) begin
          in_escape_nxt  = 1'b0;
          body_count_nxt = '0;
          if (res.ok) begin
            out_valid_nxt    = 1'b1;
            out_nxt.out_byte = res.code;
          end else begin
            error_seen_nxt = 1'b1;
          end
        end else if (body_count_r < CNT_W'(BODY_BYTES)) begin
          body_we        = 1'b1;
          body_count_nxt = body_count_r + 1'b1;
        end else begin
          error_seen_nxt = 1'b1;
          in_escape_nxt  = 1'b0;
          body_count_nxt = '0;
        end
      end else if (!is_text(s1_r.in_byte)) begin
        error_seen_nxt = 1'b1;
      end else if (s1_r.in_byte == CH_PERCENT) begin
        in_escape_nxt  = 1'b1;
        body_count_nxt = '0;
      end else begin
        out_valid_nxt    = 1'b1;
        out_nxt.out_byte = s1_r.in_byte[6:0];
      end
    end
  end

  // decode state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_open_r <= 1'b1;
      in_escape_r   <= 1'b0;
      error_seen_r  <= 1'b0;
      body_count_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      expect_open_r <= expect_open_nxt;
      in_escape_r   <= in_escape_nxt;
      error_seen_r  <= error_seen_nxt;
      body_count_r  <= body_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    if (out_free) begin
      out_r <= out_nxt;
    end
  end

  // escape body buffer
  always_ff @(posedge clk) begin
    if (fire && body_we) begin
      body_r[body_count_r[IDX_W-1:0]] <= s1_r.in_byte;
    end
  end

endmodule

// ===== rtl/asu_checker.sv =====
module asu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input asu_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input asu_pkg::out_item_t out_data
);
  import asu_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a stalled input transaction stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // end transactions carry no character
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_end |-> out_data.out_byte == 7'd0)
    else $error("end transaction with nonzero character");

  // character transactions never report failure
  a_char_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_end |-> !out_data.failed)
    else $error("character transaction marked failed");

  // nothing leaves the block right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("activity right after reset");

endmodule

bind ascii_string_unescape_unit asu_checker u_asu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import asu_pkg::*;

  localparam int BODY_BYTES   = 10;
  localparam int ITEM_TARGET  = 1300;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    SEG_CHAR,
    SEG_NAME,
    SEG_HEX,
    SEG_NOISE,
    SEG_UNKNOWN,
    SEG_OVERLONG,
    SEG_BIG_HEX,
    SEG_RAW_BODY
  } seg_kind_t;

  typedef enum int {
    RX_NEVER,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  // decoder model and store of expected results
  class unescape_scoreboard;
    out_item_t   pending_results[$];
    bit          expect_open;
    bit          in_escape;
    bit          error_seen;
    byte unsigned body[BODY_BYTES];
    int          body_count;
    string       esc_names[67];
    int          esc_codes[67];
    int          mismatches;
    int          chars_checked;
    int          ends_checked;
    int          failed_literals;

    function new();
      esc_names = '{"SOH", "STX", "ETX", "EOT", "ENQ", "ACK", "a", "b", "t", "n",
                    "v", "f", "r", "SO", "SI", "DLE", "DC1", "DC2", "DC3", "DC4",
                    "NAK", "SYN", "ETB", "CAN", "EM", "SUB", "e", "FS", "GS", "RS",
                    "US", "DEL", "space", "bang", "quote", "hash", "dollar", "%",
                    "percent", "amp", "", "tick", "lparen", "rparen", "star", "plus",
                    "comma", "dash", "dot", "slash", "colon", "semi", "langle",
                    "equal", "rangle", "question", "at", "lbracket", "backslash",
                    "rbracket", "caret", "underscore", "backtick", "lbrace", "pipe",
                    "rbrace", "tilde"};
      esc_codes = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19,
                    20, 21, 22, 23, 24, 25, 26, 27, 28, 29, 30, 31, 127, 32, 33, 34,
                    35, 36, 37, 37, 38, 39, 39, 40, 41, 42, 43, 44, 45, 46, 47, 58, 59,
                    60, 61, 62, 63, 64, 91, 92, 93, 94, 95, 96, 123, 124, 125, 126};
      clear_literal();
      body_count = 0;
    endfunction

    function void clear_literal();
      expect_open = 1'b1;
      in_escape   = 1'b0;
      body_count  = 0;
      error_seen  = 1'b0;
    endfunction

    function bit text_byte(byte unsigned c);
      return (c >= 8'h09 && c <= 8'h0D) || (c >= 8'h20 && c <= 8'h7E);
    endfunction

    function int hex_of(byte unsigned c);
      if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
      if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
      if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
      return -1;
    endfunction

    // numeric or named escape body, -1 when it cannot be decoded
    function int decode_body();
      int          pos;
      int unsigned acc;
      int          j;
      if (body_count >= 1 && body[0] >= CH_ZERO && body[0] <= CH_NINE) begin
        if (body_count > 6) return -1;
        pos = 0;
        acc = 0;
        if (body_count >= 3 && body[0] == CH_ZERO &&
            (body[1] == CH_LOW_X || body[1] == CH_UP_X) && hex_of(body[2]) >= 0) begin
          pos = 2;
        end
        while (pos < body_count && hex_of(body[pos]) >= 0) begin
          acc = (acc << 4) | hex_of(body[pos]);
          pos++;
        end
        return (acc > 127) ? -1 : int'(acc);
      end
      // first entry of matching length and text wins
      for (int k = 0; k < 67; k++) begin
        if (esc_names[k].len() == body_count) begin
          j = 0;
          while (j < body_count && body[j] == esc_names[k][j]) j++;
          if (j == body_count) return esc_codes[k];
        end
      end
      return -1;
    endfunction

    function void push_result(int ch, bit is_end_flag, bit failed_flag);
      out_item_t r;
      r.out_byte = 7'(ch);
      r.is_end   = is_end_flag;
      r.failed   = failed_flag;
      pending_results.push_back(r);
    endfunction

    // advance the model by one accepted input transaction
    function void note_byte(in_item_t it);
      byte unsigned c;
      int           code;
      c = it.in_byte;
      if (expect_open) begin
        expect_open = 1'b0;
        if (it.is_last) begin
          clear_literal();
          push_result(0, 1'b1, 1'b0);
        end
        return;
      end
      if (it.is_last) begin
        push_result(0, 1'b1, error_seen || in_escape);
        clear_literal();
        return;
      end
      if (error_seen) return;
      if (in_escape) begin
        if (c == CH_SEMI) begin
          code = decode_body();
          in_escape  = 1'b0;
          body_count = 0;
          if (code < 0) error_seen = 1'b1;
          else push_result(code, 1'b0, 1'b0);
        end else if (body_count < BODY_BYTES) begin
          body[body_count] = c;
          body_count++;
        end else begin
          // body longer than the buffer
          error_seen = 1'b1;
          in_escape  = 1'b0;
          body_count = 0;
        end
        return;
      end
      if (!text_byte(c)) begin
        error_seen = 1'b1;
      end else if (c == CH_PERCENT) begin
        in_escape  = 1'b1;
        body_count = 0;
      end else begin
        push_result(c, 1'b0, 1'b0);
      end
    endfunction

    // compare one output transaction with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: out_byte %0d is_end %0d failed %0d",
               got.out_byte, got.is_end, got.failed);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte mismatch: expected %0d, actual %0d", want.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.is_end !== want.is_end) begin
        $error("is_end mismatch: expected %0d, actual %0d", want.is_end, got.is_end);
        mismatches++;
      end
      if (got.failed !== want.failed) begin
        $error("failed mismatch: expected %0d, actual %0d", want.failed, got.failed);
        mismatches++;
      end
      if (want.is_end) begin
        ends_checked++;
        if (want.failed) failed_literals++;
      end else begin
        chars_checked++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  unescape_scoreboard sb = new();

  byte unsigned lit_q[$];
  int           burst_left;
  int           gap_max;
  rx_mode_t     rx_mode = RX_NEVER;
  bit           hold_req;
  int           holds_done;
  int           items_sent;
  int           literals_sent;
  int           in_stall_cycles;
  int           idle_cycles;

  ascii_string_unescape_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // monitors on both channels plus the no-progress watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_byte(in_data);
      if (in_valid && in_stall) in_stall_cycles++;
      if (out_valid === 1'b1 && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // result side stall pattern, with an occasional long hold-off
  initial begin
    int pat;
    pat = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
        out_stall <= 1'b0;
      end else begin
        pat++;
        case (rx_mode)
          RX_RANDOM:  out_stall <= ($urandom_range(0, 99) < 35);
          RX_PATTERN: out_stall <= ((pat % 7) < 3);
          default:    out_stall <= 1'b0;
        endcase
      end
    end
  end

  // offer one byte in bursts with random gaps, return once accepted
  task automatic send_item(input logic [7:0] b, input logic last_flag);
    int       gap;
    in_item_t t;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    t.in_byte = b;
    t.is_last = last_flag;
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // opener, queued content, closer; negative closer picks one at random
  task automatic send_lit(input int closer);
    int c;
    send_item(8'($urandom_range(0, 255)), 1'b0);
    foreach (lit_q[i]) send_item(lit_q[i], 1'b0);
    c = closer;
    if (c < 0) begin
      case ($urandom_range(0, 9))
        0:       c = CH_SEMI;
        1:       c = CH_PERCENT;
        default: c = $urandom_range(0, 255);
      endcase
    end
    send_item(8'(c), 1'b1);
    literals_sent++;
    lit_q.delete();
  endtask

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) lit_q.push_back(s[i]);
  endfunction

  function automatic byte unsigned rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A))
                                : 8'($urandom_range(8'h41, 8'h5A));
  endfunction

  // numeric escape with optional prefix, padding, mixed case and junk
  function automatic void add_hex(bit in_range);
    int unsigned  val;
    string        hs;
    bit           prefixed;
    byte unsigned ch;
    val = in_range ? $urandom_range(0, 127) : $urandom_range(128, 4095);
    hs = $sformatf("%0x", val);
    prefixed = $urandom_range(0, 1);
    lit_q.push_back(CH_PERCENT);
    if (prefixed) begin
      lit_q.push_back(CH_ZERO);
      lit_q.push_back($urandom_range(0, 1) ? CH_LOW_X : CH_UP_X);
    end
    if ((!prefixed && hs[0] > CH_NINE) || $urandom_range(0, 3) == 0) lit_q.push_back(CH_ZERO);
    for (int i = 0; i < hs.len(); i++) begin
      ch = hs[i];
      if (ch >= 8'h61 && $urandom_range(0, 1)) ch = ch - 8'h20;
      lit_q.push_back(ch);
    end
    if ($urandom_range(0, 4) == 0) lit_q.push_back(8'($urandom_range(8'h67, 8'h7A)));
    lit_q.push_back(CH_SEMI);
  endfunction

  function automatic void add_segment(seg_kind_t kind);
    byte unsigned c;
    int           n;
    case (kind)
      SEG_CHAR: begin
        do c = 8'($urandom_range(8'h09, 8'h7E));
        while (!sb.text_byte(c) || c == CH_PERCENT);
        lit_q.push_back(c);
      end
      SEG_NAME: begin
        lit_q.push_back(CH_PERCENT);
        push_str(sb.esc_names[$urandom_range(0, 66)]);
        lit_q.push_back(CH_SEMI);
      end
      SEG_HEX:     add_hex(1'b1);
      SEG_BIG_HEX: add_hex(1'b0);
      SEG_NOISE: begin
        do c = 8'($urandom_range(0, 255));
        while (sb.text_byte(c));
        lit_q.push_back(c);
      end
      SEG_UNKNOWN: begin
        lit_q.push_back(CH_PERCENT);
        repeat ($urandom_range(1, BODY_BYTES)) lit_q.push_back(rand_letter());
        lit_q.push_back(CH_SEMI);
      end
      SEG_OVERLONG: begin
        lit_q.push_back(CH_PERCENT);
        repeat ($urandom_range(BODY_BYTES + 1, BODY_BYTES + 3)) lit_q.push_back(rand_letter());
        lit_q.push_back(CH_SEMI);
      end
      default: begin
        // arbitrary body bytes, high ones included
        n = $urandom_range(0, BODY_BYTES);
        lit_q.push_back(CH_PERCENT);
        repeat (n) begin
          do c = 8'($urandom_range(0, 255));
          while (c == CH_SEMI);
          lit_q.push_back(c);
        end
        lit_q.push_back(CH_SEMI);
      end
    endcase
  endfunction

  // mostly well-formed literals, the rest carry broken content
  function automatic void build_literal(bit clean);
    seg_kind_t kind;
    lit_q.delete();
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, clean ? 5 : 10))
        0, 1:    kind = SEG_CHAR;
        2, 3:    kind = SEG_NAME;
        4, 5:    kind = SEG_HEX;
        6:       kind = SEG_NOISE;
        7:       kind = SEG_UNKNOWN;
        8:       kind = SEG_OVERLONG;
        9:       kind = SEG_BIG_HEX;
        default: kind = SEG_RAW_BODY;
      endcase
      add_segment(kind);
    end
    if (!clean && $urandom_range(0, 3) == 0) begin
      lit_q.push_back(CH_PERCENT);
      repeat ($urandom_range(0, 3)) lit_q.push_back(rand_letter());
    end
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: opener that also closes, tilde and tab, prefixed hex of 127
    gap_max = 0;
    send_item(8'h00, 1'b1);
    send_lit(-1);
    lit_q.push_back(8'h7E);
    lit_q.push_back(8'h09);
    push_str("%0x7F;");
    send_lit(-1);
    // empty escape body, then a non-text byte that spoils the literal
    push_str("%;");
    send_lit(-1);
    lit_q.push_back(8'hFF);
    push_str("A");
    send_lit(-1);
    // escape still open when the closing ';' arrives
    push_str("%n");
    send_lit(CH_SEMI);

    // random phases with different idling on each side
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_max = 0; rx_mode = RX_NEVER;   end
        1: begin gap_max = 6; rx_mode = RX_RANDOM;  end
        2: begin gap_max = 3; rx_mode = RX_PATTERN; end
        default: begin
          gap_max = 8;
          rx_mode = RX_RANDOM;
          hold_req = 1'b1;
        end
      endcase
      while (items_sent < (ph + 1) * ITEM_TARGET / 4) begin
        build_literal($urandom_range(0, 99) < 75);
        send_lit(-1);
      end
    end

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d literals in %0d bytes; %0d characters and %0d end results checked",
             literals_sent, items_sent, sb.chars_checked, sb.ends_checked);
    $display("%0d literals reported failed, %0d long hold-offs, %0d input stall cycles",
             sb.failed_literals, holds_done, in_stall_cycles);
    if (sb.mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
